// ----- rtl/lrut_pkg.sv -----
package lrut_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int TAG_W = 16;
    localparam int REC_W = 64;
    localparam int TIME_W = 48;
    localparam int TTL_W = 32;
    localparam int CAP_W = 5;
    localparam int STATUS_W = 4;

    typedef enum logic [1:0] {
        KIND_GET = 2'd0,
        KIND_PUT = 2'd1,
        KIND_INV = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT = 4'd0,
        ST_MISS = 4'd1,
        ST_EXPIRED = 4'd2,
        ST_UPDATED = 4'd3,
        ST_INSERTED = 4'd4,
        ST_EVICTING = 4'd5,
        ST_REJECTED = 4'd6,
        ST_INVALIDATED = 4'd7,
        ST_ABSENT = 4'd8,
        ST_DISABLED = 4'd9
    } status_t;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_TTL = 2'd2;
endpackage

// ----- rtl/lrut_ram.sv -----
module lrut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/lru_ttl_cache.sv -----
// Channel  Dir  tdata fields (low bit up)                          tuser
// s_       in   table_tag, record_id, row_id, row_data, now_ms      kind
// m_       out  read_data                                            status
// cfg      in   cfg_we, cfg_index (0 enable, 1 capacity, 2 ttl_ms), cfg_data
//
// Each item passes through one scan over the entry memories to find the key, the
// entry count and the first free slot, then decide, one pass of rank
// read-modify-write, write-back, output and idle; both passes use the read address
// shared by the three memories. A new item is accepted only in idle. An insert that
// evicts adds one more pass over the ranks to locate the lru entry.
// Reset (aresetn low, synchronous) clears valid bits and resets control registers;
// the entry memories need no clearing. A result held by m_tready low stalls only
// the output step of the next item.
module lru_ttl_cache
    import lrut_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // table_tag[15:0], record_id[79:16], row_id[143:80], row_data[207:144],
    // now_ms[255:208]
    input  logic [255:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data[63:0]
    output logic [63:0]  m_tdata,
    // status[3:0]
    output logic [3:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = TAG_W + REC_W;
    localparam int SW = TIME_W + DATA_WIDTH;

    // rank action: touch, remove, insert (all valid +1)
    localparam logic [1:0] RA_NONE = 2'd0;
    localparam logic [1:0] RA_TOUCH = 2'd1;
    localparam logic [1:0] RA_REMOVE = 2'd2;
    localparam logic [1:0] RA_INSERT = 2'd3;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_RANK, S_WB, S_OUT} state_t;

    state_t state_reg;
    logic en_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [TTL_W-1:0] ttl_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic [1:0] kind_reg;
    logic [KW-1:0] key_reg;
    logic rowz_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [TIME_W-1:0] now_reg;

    logic [IW:0] idx_reg;      // address issued
    logic [IW:0] cidx_reg;     // address whose data is on rdata
    logic rd_v_reg;
    logic found_reg;
    logic [IW-1:0] hit_reg;
    logic [IW-1:0] hit_rank_reg;
    logic [DATA_WIDTH-1:0] hit_data_reg;
    logic [TIME_W-1:0] hit_stamp_reg;
    logic lru_f_reg;
    logic [IW-1:0] lru_reg;
    logic free_f_reg;
    logic [IW-1:0] free_reg;
    logic [CW-1:0] count_reg;

    logic [1:0] ract_reg;
    logic [IW-1:0] rref_reg;
    logic [IW-1:0] target_reg;
    logic tgt_we_reg;
    logic tgt_set_valid_reg;
    logic tgt_clr_valid_reg;
    logic tgt_key_we_reg;
    logic tgt_stamp_we_reg;
    logic [3:0] status_reg;
    logic [63:0] rdo_reg;

    logic m_valid_reg;
    logic [63:0] m_data_reg;
    logic [3:0] m_user_reg;

    // memories
    logic key_we, ent_we, rank_we;
    logic [IW-1:0] key_wa, ent_wa, rank_wa, ra;
    logic [KW-1:0] key_wd, key_rd;
    logic [SW-1:0] ent_wd, ent_rd;
    logic [IW-1:0] rank_wd, rank_rd;

    lrut_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key (
        .aclk, .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(ra), .rdata(key_rd));
    lrut_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_ent (
        .aclk, .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ra), .rdata(ent_rd));
    lrut_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank (
        .aclk, .we(rank_we), .waddr(rank_wa), .wdata(rank_wd), .raddr(ra),
        .rdata(rank_rd));

    assign ra = idx_reg[IW-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;

    logic [IW-1:0] cidx;
    logic cvalid;
    logic [TIME_W-1:0] age;
    logic expired;
    logic [CW-1:0] cap_eff;
    logic [IW-1:0] rank_new;
    logic rank_do;

    logic dec_we, dec_set, dec_clr, dec_key, dec_stamp;
    logic [1:0] dec_ract;
    logic [IW-1:0] dec_rref;
    logic [IW-1:0] dec_target;
    logic [3:0] dec_status;
    logic [63:0] dec_rdo;

    assign cidx = cidx_reg[IW-1:0];
    assign cvalid = rd_v_reg && valid_reg[cidx];
    assign age = (now_reg >= hit_stamp_reg) ? now_reg - hit_stamp_reg : '0;
    assign expired = (ttl_reg != '0) && (age >= TIME_W'(ttl_reg));

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (32'(cap_reg) > 32'(ENTRIES)) begin
            cap_eff = CW'(ENTRIES);
        end else begin
            cap_eff = CW'(cap_reg);
        end
    end

    // outcome of the scan, latched in S_DECIDE
    always_comb begin
        dec_we = 1'b0;
        dec_set = 1'b0;
        dec_clr = 1'b0;
        dec_key = 1'b0;
        dec_stamp = 1'b0;
        dec_ract = RA_NONE;
        dec_rref = hit_rank_reg;
        dec_target = hit_reg;
        dec_rdo = '0;
        dec_status = ST_MISS;
        if (!en_reg) begin
            dec_status = ST_DISABLED;
        end else begin
            case (kind_reg)
                KIND_GET: begin
                    if (!found_reg) begin
                        dec_status = ST_MISS;
                    end else if (expired) begin
                        dec_status = ST_EXPIRED;
                        dec_ract = RA_REMOVE;
                        dec_we = 1'b1;
                        dec_clr = 1'b1;
                    end else begin
                        dec_status = ST_HIT;
                        dec_rdo = 64'(hit_data_reg);
                        dec_ract = RA_TOUCH;
                        dec_we = 1'b1;
                        dec_set = 1'b1;
                    end
                end
                KIND_PUT: begin
                    if (rowz_reg) begin
                        dec_status = ST_REJECTED;
                    end else if (found_reg) begin
                        dec_status = ST_UPDATED;
                        dec_ract = RA_TOUCH;
                        dec_we = 1'b1;
                        dec_set = 1'b1;
                    end else if (count_reg >= cap_eff && count_reg != '0) begin
                        // eviction resolved by an lru lookup pass in S_RANK
                        dec_status = ST_EVICTING;
                        dec_rref = IW'(count_reg - 1'b1);
                        dec_target = free_reg;
                        dec_set = 1'b1;
                        dec_key = 1'b1;
                        dec_stamp = 1'b1;
                    end else begin
                        dec_status = ST_INSERTED;
                        dec_ract = RA_INSERT;
                        dec_target = free_reg;
                        dec_we = 1'b1;
                        dec_set = 1'b1;
                        dec_key = 1'b1;
                        dec_stamp = 1'b1;
                    end
                end
                KIND_INV: begin
                    if (found_reg) begin
                        dec_status = ST_INVALIDATED;
                        dec_ract = RA_REMOVE;
                        dec_we = 1'b1;
                        dec_clr = 1'b1;
                    end else begin
                        dec_status = ST_ABSENT;
                    end
                end
                default: dec_status = ST_MISS;
            endcase
        end
    end

    // rank update for entry on rdata during S_RANK
    always_comb begin
        rank_new = rank_rd;
        rank_do = 1'b0;
        if (cvalid && !(tgt_we_reg && cidx == target_reg)) begin
            case (ract_reg)
                RA_TOUCH: begin
                    if (rank_rd < rref_reg) begin
                        rank_new = rank_rd + 1'b1;
                        rank_do = 1'b1;
                    end
                end
                RA_REMOVE: begin
                    if (rank_rd > rref_reg) begin
                        rank_new = rank_rd - 1'b1;
                        rank_do = 1'b1;
                    end
                end
                RA_INSERT: begin
                    rank_new = rank_rd + 1'b1;
                    rank_do = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        key_we = 1'b0;
        key_wa = target_reg;
        key_wd = key_reg;
        ent_we = 1'b0;
        ent_wa = target_reg;
        ent_wd = {tgt_stamp_we_reg ? now_reg : hit_stamp_reg, data_reg};
        rank_we = 1'b0;
        rank_wa = cidx;
        rank_wd = rank_new;
        if (state_reg == S_RANK && rank_do) begin
            rank_we = 1'b1;
        end
        if (state_reg == S_WB && tgt_we_reg) begin
            key_we = tgt_key_we_reg;
            ent_we = tgt_set_valid_reg;
            rank_we = tgt_set_valid_reg;
            rank_wa = target_reg;
            rank_wd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            en_reg <= 1'b1;
            cap_reg <= CAP_W'(ENTRIES_DEF);
            ttl_reg <= '0;
            valid_reg <= '0;
            m_valid_reg <= 1'b0;
            idx_reg <= '0;
            cidx_reg <= '0;
            rd_v_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ENABLE: en_reg <= cfg_data[0];
                    CFG_CAPACITY: cap_reg <= cfg_data[CAP_W-1:0];
                    CFG_TTL: ttl_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            rd_v_reg <= (state_reg == S_SCAN || state_reg == S_RANK) &&
                        (idx_reg < (IW+1)'(ENTRIES));
            cidx_reg <= idx_reg;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg <= s_tuser;
                        key_reg <= s_tdata[79:0];
                        rowz_reg <= (s_tdata[143:80] == '0);
                        data_reg <= s_tdata[144 +: DATA_WIDTH];
                        now_reg <= s_tdata[255:208];
                        found_reg <= 1'b0;
                        lru_f_reg <= 1'b0;
                        free_f_reg <= 1'b0;
                        count_reg <= '0;
                        idx_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (idx_reg < (IW+1)'(ENTRIES)) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (cvalid) begin
                        count_reg <= count_reg + 1'b1;
                        if (key_rd == key_reg && !found_reg) begin
                            found_reg <= 1'b1;
                            hit_reg <= cidx;
                            hit_rank_reg <= rank_rd;
                            hit_data_reg <= ent_rd[DATA_WIDTH-1:0];
                            hit_stamp_reg <= ent_rd[SW-1:DATA_WIDTH];
                        end
                    end
                    if (rd_v_reg && !valid_reg[cidx] && !free_f_reg) begin
                        free_f_reg <= 1'b1;
                        free_reg <= cidx;
                    end
                    if (!rd_v_reg && idx_reg == (IW+1)'(ENTRIES)) begin
                        state_reg <= S_DECIDE;
                        idx_reg <= '0;
                    end
                end
                S_DECIDE: begin
                    // LRU search needs the final count: reuse a rank pass
                    tgt_we_reg <= dec_we;
                    tgt_set_valid_reg <= dec_set;
                    tgt_clr_valid_reg <= dec_clr;
                    tgt_key_we_reg <= dec_key;
                    tgt_stamp_we_reg <= dec_stamp;
                    ract_reg <= dec_ract;
                    rref_reg <= dec_rref;
                    target_reg <= dec_target;
                    rdo_reg <= dec_rdo;
                    status_reg <= dec_status;
                    if (kind_reg == KIND_GET) begin
                        data_reg <= hit_data_reg;
                    end
                    state_reg <= S_RANK;
                end
                S_RANK: begin
                    if (idx_reg < (IW+1)'(ENTRIES)) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (status_reg == ST_EVICTING && !tgt_we_reg) begin
                        // look for the lru entry; apply eviction then rerun as insert
                        if (cvalid && rank_rd == rref_reg && !lru_f_reg) begin
                            lru_f_reg <= 1'b1;
                            lru_reg <= cidx;
                        end
                        if (!rd_v_reg && idx_reg == (IW+1)'(ENTRIES)) begin
                            idx_reg <= '0;
                            if (lru_f_reg) begin
                                // evicted entry sits at the bottom: all others +1
                                valid_reg[lru_reg] <= 1'b0;
                                target_reg <= lru_reg;
                                free_reg <= lru_reg;
                            end else begin
                                status_reg <= ST_INSERTED;
                                target_reg <= free_reg;
                            end
                            tgt_we_reg <= lru_f_reg || free_f_reg;
                            ract_reg <= (lru_f_reg || free_f_reg) ? RA_INSERT : RA_NONE;
                        end
                    end else begin
                        if (!rd_v_reg && idx_reg == (IW+1)'(ENTRIES)) begin
                            state_reg <= S_WB;
                        end
                    end
                end
                S_WB: begin
                    if (tgt_we_reg) begin
                        if (tgt_clr_valid_reg) begin
                            valid_reg[target_reg] <= 1'b0;
                        end
                        if (tgt_set_valid_reg) begin
                            valid_reg[target_reg] <= 1'b1;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg <= rdo_reg;
                        m_user_reg <= status_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hit_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_HIT |-> m_tdata == '0)
        else $error("nonzero data on non-hit");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_SCAN)
        else $error("accept did not start scan");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_DISABLED)
        else $error("status code out of range");
`endif
endmodule
